// ===== design/ps2md_pkg.sv =====
// Shared constants for the PS/2 mouse packet decoder: packet phases, status bits, event kinds.
package ps2md_pkg;

    // Packet assembly phase codes
    localparam logic [1:0] PH_STATUS = 2'd0;
    localparam logic [1:0] PH_X      = 2'd1;
    localparam logic [1:0] PH_Y      = 2'd2;
    localparam logic [1:0] PH_SPARE  = 2'd3;   // never entered from reset

    // Status byte bit positions
    localparam int ALWAYS_ONE_POS = 3;
    localparam int X_SIGN_POS     = 4;
    localparam int Y_SIGN_POS     = 5;
    localparam int BUTTON_W       = 3;

    // Event kinds; each kind is also its bit position in the pending mask
    localparam logic [2:0] KIND_X      = 3'd0;
    localparam logic [2:0] KIND_Y      = 3'd1;
    localparam logic [2:0] KIND_LEFT   = 3'd2;
    localparam logic [2:0] KIND_RIGHT  = 3'd3;
    localparam logic [2:0] KIND_MIDDLE = 3'd4;
    localparam logic [2:0] KIND_SYNC   = 3'd5;

    localparam int KIND_COUNT = 6;
    localparam int VALUE_W    = 10;

    typedef logic [KIND_COUNT-1:0] event_mask_t;
    typedef logic signed [VALUE_W-1:0] event_value_t;

endpackage

// ===== design/ps2_mouse_packet_decoder.sv =====
// PS/2 mouse packet decoder: assembles three-byte packets and emits motion/button events.
//
// Bytes from the mouse enter through an input register, one transaction per cycle while
// in_stall is low. Status and X bytes (and a misaligned first byte, which is dropped) only
// update the packet state. The third byte of a packet is decoded in one pass into a
// pending-event mask plus X/Y deltas and buttons; the output register then issues one
// event per cycle from that mask while out_stall is low, in the order X, Y, left, right,
// middle, sync, so a packet with events causes two to six of them, and a quiet packet
// leaves the event stage untouched. The next byte is taken while the last event of the
// previous packet still waits in the output register. A byte passes through the input
// register, the pending-event mask and the output register. last_of_run marks the final
// event (always the sync) of a packet.
module ps2_mouse_packet_decoder
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                rx_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                event_kind,
    output ps2md_pkg::event_value_t   event_value,
    output logic                      last_of_run
);

    // Input register
    logic       ib_valid_reg;
    logic       ib_valid_next;
    logic [7:0] ib_byte_reg;
    logic       ib_take;

    // Packet state
    logic [1:0]                     phase_reg;
    logic [1:0]                     phase_next;
    logic [7:0]                     status_reg;
    logic [7:0]                     status_next;
    logic [7:0]                     x_low_reg;
    logic [7:0]                     x_low_next;
    logic [ps2md_pkg::BUTTON_W-1:0] buttons_reg;
    logic [ps2md_pkg::BUTTON_W-1:0] buttons_next;

    // Decode of the byte in the input register
    ps2md_pkg::event_mask_t         dec_mask;
    ps2md_pkg::event_value_t        dec_dx;
    ps2md_pkg::event_value_t        dec_dy;
    logic [9:0]                     dec_y9;
    logic [ps2md_pkg::BUTTON_W-1:0] dec_buttons;
    logic [ps2md_pkg::BUTTON_W-1:0] dec_changed;
    logic                           dec_any;

    // Event stage
    ps2md_pkg::event_mask_t         pend_reg;
    ps2md_pkg::event_mask_t         pend_next;
    ps2md_pkg::event_mask_t         pend_after;
    ps2md_pkg::event_mask_t         sel_onehot;
    ps2md_pkg::event_value_t        dx_reg;
    ps2md_pkg::event_value_t        dy_reg;
    logic [ps2md_pkg::BUTTON_W-1:0] btn_reg;
    logic [2:0]                     sel_kind;
    ps2md_pkg::event_value_t        sel_value;
    logic                           issue;
    logic                           work_free;

    // Output register
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [2:0]                     kind_reg;
    ps2md_pkg::event_value_t        value_reg;
    logic                           last_reg;
    logic                           out_free;

    // Decode: motion deltas, button changes and the set of events to emit
    always_comb
    begin
        dec_dx      = ps2md_pkg::event_value_t'({{2{status_reg[ps2md_pkg::X_SIGN_POS]}},
                                                 x_low_reg});
        dec_y9      = {{2{status_reg[ps2md_pkg::Y_SIGN_POS]}}, ib_byte_reg};
        dec_dy      = ps2md_pkg::event_value_t'(10'd0 - dec_y9);
        dec_buttons = status_reg[ps2md_pkg::BUTTON_W-1:0];
        dec_changed = dec_buttons ^ buttons_reg;
        dec_mask    = '0;
        if (phase_reg == ps2md_pkg::PH_Y)
        begin
            dec_mask[ps2md_pkg::KIND_X]      = (dec_dx != '0);
            dec_mask[ps2md_pkg::KIND_Y]      = (dec_dy != '0);
            dec_mask[ps2md_pkg::KIND_LEFT]   = dec_changed[0];
            dec_mask[ps2md_pkg::KIND_RIGHT]  = dec_changed[1];
            dec_mask[ps2md_pkg::KIND_MIDDLE] = dec_changed[2];
            dec_mask[ps2md_pkg::KIND_SYNC]   = (dec_dx != '0) || (dec_dy != '0) ||
                                               (dec_changed != '0);
        end
        dec_any = (dec_mask != '0);
    end

    // Next packet state when the input byte is consumed
    always_comb
    begin
        phase_next   = phase_reg;
        status_next  = status_reg;
        x_low_next   = x_low_reg;
        buttons_next = buttons_reg;
        if (ib_take)
        begin
            priority if (phase_reg == ps2md_pkg::PH_X)
            begin
                x_low_next = ib_byte_reg;
                phase_next = ps2md_pkg::PH_Y;
            end
            else if (phase_reg == ps2md_pkg::PH_Y)
            begin
                buttons_next = dec_buttons;
                phase_next   = ps2md_pkg::PH_STATUS;
            end
            else if (ib_byte_reg[ps2md_pkg::ALWAYS_ONE_POS])
            begin
                // first byte only when its always-one bit is set
                status_next = ib_byte_reg;
                phase_next  = ps2md_pkg::PH_X;
            end
        end
    end

    // Pick the lowest pending event
    always_comb
    begin
        sel_kind   = ps2md_pkg::KIND_SYNC;
        sel_onehot = '0;
        for (int i = ps2md_pkg::KIND_COUNT - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                sel_kind   = 3'(i);
                sel_onehot = ps2md_pkg::event_mask_t'(1) << i;
            end
        end
        unique case (sel_kind)
            ps2md_pkg::KIND_X:      sel_value = dx_reg;
            ps2md_pkg::KIND_Y:      sel_value = dy_reg;
            ps2md_pkg::KIND_LEFT:   sel_value = ps2md_pkg::event_value_t'(btn_reg[0]);
            ps2md_pkg::KIND_RIGHT:  sel_value = ps2md_pkg::event_value_t'(btn_reg[1]);
            ps2md_pkg::KIND_MIDDLE: sel_value = ps2md_pkg::event_value_t'(btn_reg[2]);
            default:                sel_value = '0;
        endcase
    end

    // Handshake and event-stage flow
    always_comb
    begin
        out_free   = !out_valid_reg || !out_stall;
        issue      = out_free && (pend_reg != '0);
        pend_after = issue ? (pend_reg & ~sel_onehot) : pend_reg;
        work_free  = (pend_after == '0);
        ib_take    = ib_valid_reg && (work_free || !dec_any);
        in_stall   = ib_valid_reg && !ib_take;
        pend_next  = (ib_take && dec_any) ? dec_mask : pend_after;

        ib_valid_next = ib_valid_reg && !ib_take;
        if (in_valid && !in_stall)
        begin
            ib_valid_next = 1'b1;
        end

        out_valid_next = out_valid_reg && out_stall;
        if (out_free)
        begin
            out_valid_next = (pend_reg != '0);
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ib_valid_reg  <= 1'b0;
            phase_reg     <= ps2md_pkg::PH_STATUS;
            status_reg    <= '0;
            x_low_reg     <= '0;
            buttons_reg   <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ib_valid_reg  <= ib_valid_next;
            phase_reg     <= phase_next;
            status_reg    <= status_next;
            x_low_reg     <= x_low_next;
            buttons_reg   <= buttons_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            ib_byte_reg <= rx_byte;
        end
        if (ib_take && dec_any)
        begin
            dx_reg  <= dec_dx;
            dy_reg  <= dec_dy;
            btn_reg <= dec_buttons;
        end
        if (issue)
        begin
            kind_reg  <= sel_kind;
            value_reg <= sel_value;
            last_reg  <= ((pend_reg & ~sel_onehot) == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_kind  = kind_reg;
    assign event_value = value_reg;
    assign last_of_run = last_reg;

`ifndef SYNTHESIS
    // Any pending motion or button event always brings a closing sync
    a_sync_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg[ps2md_pkg::KIND_COUNT-2:0] != '0) |-> pend_reg[ps2md_pkg::KIND_SYNC])
        else $error("pending events without sync");

    // Unused phase code is never reached
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != ps2md_pkg::PH_SPARE)
        else $error("packet phase left the legal range");

    // A completing byte with events lands in the event stage
    a_load_events: assert property (@(posedge clk) disable iff (!rst_n)
        (ib_take && dec_any) |=> (pend_reg != '0))
        else $error("decoded events were lost");

    // The sync event closes its run
    a_sync_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == ps2md_pkg::KIND_SYNC)) |-> last_reg)
        else $error("sync event not flagged as last");
`endif

endmodule
